### rtl/swrs_pkg.sv
// Shared types, character class codes and automaton state codes for the word scanner.
// Holds the character classifier and the next-state table. No dependencies.
package swrs_pkg;

    typedef logic [2:0] cls_t;
    typedef logic [3:0] state_t;

    // Character classes
    localparam cls_t CLS_NONE  = 3'd0;
    localparam cls_t CLS_BIN   = 3'd1;
    localparam cls_t CLS_DOT   = 3'd2;
    localparam cls_t CLS_DIG   = 3'd3;
    localparam cls_t CLS_B     = 3'd4;
    localparam cls_t CLS_SEP   = 3'd5;
    localparam cls_t CLS_OTHER = 3'd6;
    localparam cls_t CLS_END   = 3'd7;

    localparam logic [7:0] CHAR_ZERO = 8'h30;
    localparam logic [7:0] CHAR_ONE  = 8'h31;
    localparam logic [7:0] CHAR_TWO  = 8'h32;
    localparam logic [7:0] CHAR_NINE = 8'h39;
    localparam logic [7:0] CHAR_DOT  = 8'h2E;
    localparam logic [7:0] CHAR_B    = 8'h42;
    localparam logic [7:0] CHAR_SEP  = 8'h23;
    localparam logic [7:0] CHAR_END  = 8'h00;

    // Automaton states; codes above S_ERR exist only as next-state results
    localparam state_t S_START    = 4'd0;
    localparam state_t S_ONE_BIT  = 4'd1;
    localparam state_t S_B_SEEN   = 4'd2;
    localparam state_t S_BITS     = 4'd3;
    localparam state_t S_DOT_SEEN = 4'd4;
    localparam state_t S_ERR      = 4'd5;
    localparam state_t S_END_IDLE = 4'd6;
    localparam state_t S_DONE_SEP = 4'd7;
    localparam state_t S_DONE_END = 4'd8;

    // Depth of the class queue between front and back
    localparam int QDEPTH = 4;

    function automatic cls_t classify(input logic [7:0] ch);
        cls_t c;
        if (ch == CHAR_ZERO || ch == CHAR_ONE) c = CLS_BIN;
        else if (ch == CHAR_DOT) c = CLS_DOT;
        else if (ch >= CHAR_TWO && ch <= CHAR_NINE) c = CLS_DIG;
        else if (ch == CHAR_B) c = CLS_B;
        else if (ch == CHAR_SEP) c = CLS_SEP;
        else if (ch == CHAR_END) c = CLS_END;
        else c = CLS_OTHER;
        return c;
    endfunction

    // One row per state, indexed by class (class code NONE never occurs).
    function automatic state_t next_state(input state_t st, input cls_t c);
        logic [7:0][3:0] row;
        case (st)
            S_START:    row = {S_END_IDLE, S_ERR, S_START, S_B_SEEN,
                               S_ERR, S_ERR, S_ONE_BIT, S_ERR};
            S_ONE_BIT:  row = {S_END_IDLE, S_ERR, S_START, S_B_SEEN,
                               S_ERR, S_DOT_SEEN, S_BITS, S_ERR};
            S_B_SEEN:   row = {S_DONE_END, S_ERR, S_DONE_SEP, S_ERR,
                               S_ERR, S_ERR, S_ERR, S_ERR};
            S_BITS:     row = {S_END_IDLE, S_ERR, S_START, S_B_SEEN,
                               S_ERR, S_ERR, S_BITS, S_ERR};
            S_DOT_SEEN: row = {S_DONE_END, S_ERR, S_DONE_SEP, S_ERR,
                               S_B_SEEN, S_ERR, S_B_SEEN, S_ERR};
            default:    row = {S_END_IDLE, S_ERR, S_START, S_ERR,
                               S_ERR, S_ERR, S_ERR, S_ERR};
        endcase
        return row[c];
    endfunction

endpackage

### rtl/swrs_front.sv
// Front stage: accepts character beats, classifies them and holds the class
// until the queue takes it. Depends on swrs_pkg.
module swrs_front (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_axis_tvalid,
    output logic              s_axis_tready,
    input  logic [7:0]        s_axis_tdata,   // [7:0] ch
    output logic              push_valid,
    input  logic              push_ready,
    output swrs_pkg::cls_t    push_cls
);

    logic           valid_reg, valid_next;
    swrs_pkg::cls_t cls_reg;

    assign s_axis_tready = !valid_reg || push_ready;
    assign push_valid    = valid_reg;
    assign push_cls      = cls_reg;

    always_comb begin
        valid_next = valid_reg;
        if (s_axis_tvalid && s_axis_tready) begin
            valid_next = 1'b1;
        end else if (push_ready) begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_axis_tvalid && s_axis_tready) begin
            cls_reg <= swrs_pkg::classify(s_axis_tdata);
        end
    end

endmodule

### rtl/swrs_queue.sv
// Short class queue between front and back stages, flip-flop storage.
// Depends on swrs_pkg.
module swrs_queue (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              in_valid,
    output logic              in_ready,
    input  swrs_pkg::cls_t    in_cls,
    output logic              out_valid,
    input  logic              out_ready,
    output swrs_pkg::cls_t    out_cls
);

    localparam int AW = $clog2(swrs_pkg::QDEPTH);
    localparam int CW = $clog2(swrs_pkg::QDEPTH + 1);

    swrs_pkg::cls_t slot_reg [swrs_pkg::QDEPTH];
    logic [AW-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [AW-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0]  count_reg, count_next;
    logic           push, pop;

    assign in_ready  = (count_reg != CW'(swrs_pkg::QDEPTH));
    assign out_valid = (count_reg != '0);
    assign out_cls   = slot_reg[rd_ptr_reg];
    assign push      = in_valid && in_ready;
    assign pop       = out_valid && out_ready;

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == AW'(swrs_pkg::QDEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == AW'(swrs_pkg::QDEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop) begin
            count_next = count_reg + 1'b1;
        end else if (pop && !push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            slot_reg[wr_ptr_reg] <= in_cls;
        end
    end

endmodule

### rtl/swrs_back.sv
// Back stage: runs the word automaton on queued classes, tracks positions and
// the word number, and holds each result in the output register. Depends on swrs_pkg.
module swrs_back #(
    parameter int MAX_LEN = 256
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              pop_valid,
    output logic              pop_ready,
    input  swrs_pkg::cls_t    pop_cls,
    output logic              m_axis_tvalid,
    input  logic              m_axis_tready,
    output logic [31:0]       m_axis_tdata
);

    localparam int PW = $clog2(MAX_LEN);

    logic [2:0]       dfa_reg, dfa_next;
    logic [PW-1:0]    pos_reg, pos_next;
    logic [PW-1:0]    start_reg, start_next;
    logic [15:0]      count_reg, count_next;
    logic             valid_reg, valid_next;
    logic [7:0]       ws_reg, we_reg;
    logic [15:0]      wn_reg;

    logic             pop, emit;
    swrs_pkg::state_t nxt;
    logic [PW-1:0]    start_use, last_pos, pos_inc;
    logic [PW+7:0]    start_ext, last_ext;

    assign pop_ready = !valid_reg || m_axis_tready;
    assign pop       = pop_valid && pop_ready;

    assign start_use = (dfa_reg == swrs_pkg::S_START[2:0]) ? pos_reg : start_reg;
    assign nxt       = swrs_pkg::next_state({1'b0, dfa_reg}, pop_cls);
    assign emit      = pop && (nxt == swrs_pkg::S_DONE_SEP || nxt == swrs_pkg::S_DONE_END);
    assign last_pos  = (pos_reg == '0) ? PW'(MAX_LEN - 1) : pos_reg - 1'b1;
    assign pos_inc   = (pos_reg == PW'(MAX_LEN - 1)) ? '0 : pos_reg + 1'b1;
    assign start_ext = {8'b0, start_use};
    assign last_ext  = {8'b0, last_pos};

    always_comb begin
        dfa_next   = dfa_reg;
        pos_next   = pos_reg;
        start_next = start_reg;
        count_next = count_reg;
        valid_next = valid_reg;
        if (pop) begin
            if (pop_cls == swrs_pkg::CLS_END) begin
                dfa_next   = swrs_pkg::S_START[2:0];
                pos_next   = '0;
                start_next = '0;
            end else begin
                dfa_next   = (nxt > swrs_pkg::S_ERR) ? swrs_pkg::S_START[2:0] : nxt[2:0];
                pos_next   = pos_inc;
                start_next = start_use;
            end
        end
        if (emit) begin
            count_next = count_reg + 1'b1;
            valid_next = 1'b1;
        end else if (m_axis_tready) begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            dfa_reg   <= swrs_pkg::S_START[2:0];
            pos_reg   <= '0;
            start_reg <= '0;
            count_reg <= 16'd1;
            valid_reg <= 1'b0;
        end else begin
            dfa_reg   <= dfa_next;
            pos_reg   <= pos_next;
            start_reg <= start_next;
            count_reg <= count_next;
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (emit) begin
            ws_reg <= start_ext[7:0];
            we_reg <= last_ext[7:0];
            wn_reg <= count_reg;
        end
    end

    assign m_axis_tvalid = valid_reg;
    assign m_axis_tdata  = {wn_reg, we_reg, ws_reg};

endmodule

### rtl/sentinel_word_regex_scanner.sv
// Top level of the word scanner: front classifier, class queue and automaton back end.
// Depends on swrs_pkg, swrs_front, swrs_queue and swrs_back.
//
//  channel | dir | tdata bits | fields (low bit up)
//  s_axis  | in  | 8          | ch[7:0]
//  m_axis  | out | 32         | word_start[7:0], word_end[15:8], word_number[31:16]
//
// One character beat is taken per cycle while s_axis_tready is high; the automaton back end
// retires one class a cycle unless a result waits on a stalled m_axis. After its closing '#'
// or end byte is taken, a result passes the front register, queue slot and output register.
// Reset clears the automaton, positions and queue; the word number restarts at 1.
// A stalled m_axis holds the back end; the four-entry queue and the front register
// keep taking characters until they fill, then s_axis_tready drops.
module sentinel_word_regex_scanner #(
    parameter int MAX_LEN = 256
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] ch
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [31:0] m_axis_tdata    // [7:0] word_start, [15:8] word_end, [31:16] word_number
);

    logic           q_in_valid, q_in_ready;
    swrs_pkg::cls_t q_in_cls;
    logic           q_out_valid, q_out_ready;
    swrs_pkg::cls_t q_out_cls;

    // Classify each character and hand it to the queue
    swrs_front u_front (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .push_valid    (q_in_valid),
        .push_ready    (q_in_ready),
        .push_cls      (q_in_cls)
    );

    // Decouple the classifier from output stalls
    swrs_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (q_in_valid),
        .in_ready  (q_in_ready),
        .in_cls    (q_in_cls),
        .out_valid (q_out_valid),
        .out_ready (q_out_ready),
        .out_cls   (q_out_cls)
    );

    // Run the automaton and emit accepted words
    swrs_back #(
        .MAX_LEN (MAX_LEN)
    ) u_back (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .pop_valid     (q_out_valid),
        .pop_ready     (q_out_ready),
        .pop_cls       (q_out_cls),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    // Back end advances only when its output register can take a result
    a_pop_needs_slot: assert property (@(posedge aclk) disable iff (!aresetn)
        (q_out_valid && q_out_ready) |-> (!m_axis_tvalid || m_axis_tready))
        else $error("automaton advanced while a result was stalled");

    // A full queue must present data to the back end
    a_full_has_data: assert property (@(posedge aclk) disable iff (!aresetn)
        !q_in_ready |-> q_out_valid)
        else $error("queue refuses beats yet reports empty");

    // A class pushed into an empty queue is visible next cycle
    a_push_visible: assert property (@(posedge aclk) disable iff (!aresetn)
        (q_in_valid && q_in_ready && !q_out_valid) |=> q_out_valid)
        else $error("pushed class lost in queue");

endmodule
